// ===== src/sxt_pkg.sv =====
// shared types, constants and helpers for the s-expression tokenizer
// used by every module of the block; depends on nothing
`default_nettype none
package sxt_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_TEXT_DEF  = 1024;
  localparam int unsigned LINE_BITS_DEF = 20;

  // fixed field widths of a result
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned LINE_W = 20;

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 4;

  // result kinds
  localparam logic [1:0] RK_TEXT  = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // token kinds
  localparam logic [3:0] TK_EOF    = 4'd0;
  localparam logic [3:0] TK_OPEN   = 4'd1;
  localparam logic [3:0] TK_CLOSE  = 4'd2;
  localparam logic [3:0] TK_STRING = 4'd3;
  localparam logic [3:0] TK_SYMBOL = 4'd4;
  localparam logic [3:0] TK_INT    = 4'd5;
  localparam logic [3:0] TK_REAL   = 4'd6;
  localparam logic [3:0] TK_TRUE   = 4'd7;
  localparam logic [3:0] TK_FALSE  = 4'd8;

  // error codes
  localparam logic ERR_STRING = 1'b0;
  localparam logic ERR_CONST  = 1'b1;

  // characters
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        tok;
    logic [7:0]        byte_v;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              err;
  } res_t;

  // one queue entry: the results of one request
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [3:0] tok, logic [7:0] b,
                                  logic [LEN_W-1:0] len, logic [LINE_W-1:0] line,
                                  logic err);
    res_t r;
    r.kind   = kind;
    r.tok    = tok;
    r.byte_v = b;
    r.len    = len;
    r.line   = line;
    r.err    = err;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sxt_front.sv =====
// lexer front end: accepts one request a cycle while the queue is not full, works out its results
// depends on sxt_pkg
`default_nettype none
module sxt_front #(
  parameter int unsigned MAX_TEXT  = sxt_pkg::MAX_TEXT_DEF,
  parameter int unsigned LINE_BITS = sxt_pkg::LINE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             end_of_input_i,
  input  wire sxt_pkg::q_stat_t q_stat_i,
  output logic                  push_o,
  output sxt_pkg::entry_t       entry_o
);

  localparam int unsigned TCW = $clog2(MAX_TEXT + 1);
  localparam int unsigned LW  = sxt_pkg::LINE_W;
  localparam int unsigned NW  = sxt_pkg::LEN_W;
  localparam logic [TCW-1:0] MaxT = TCW'(MAX_TEXT);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_STRING, M_ESCAPE, M_CONST, M_NUMBER, M_SYMBOL,
    M_ERR_STRING, M_ERR_CONST
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [TCW-1:0]       cnt_q, cnt_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [LINE_BITS-1:0] sline_q, sline_d;
  logic                 dig_q, dig_d;
  logic                 oth_q, oth_d;
  logic [1:0]           dot_q, dot_d;
  logic [7:0]           cf_q, cf_d;

  logic                 accept;
  logic [1:0]           n;
  sxt_pkg::res_t        r0, r1, em;

  function automatic logic is_space(logic [7:0] c);
    return (c == sxt_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return c == sxt_pkg::CH_QUOTE || c == sxt_pkg::CH_OPEN ||
           c == sxt_pkg::CH_CLOSE || c == sxt_pkg::CH_SEMI;
  endfunction

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    logic [7:0] c;
    logic       do_idle;
    logic       do_word;
    logic       do_store;
    logic       fc_ok;
    logic [3:0] fc_tok;
    logic [3:0] fw_tok;

    mode_d   = mode_q;
    cnt_d    = cnt_q;
    line_d   = line_q;
    sline_d  = sline_q;
    dig_d    = dig_q;
    oth_d    = oth_q;
    dot_d    = dot_q;
    cf_d     = cf_q;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    em       = '0;
    c        = in_byte_i;
    do_idle  = 1'b0;
    do_word  = 1'b0;
    do_store = 1'b0;

    // end of a constant: only #t and #f are known
    fc_ok  = (cnt_q == TCW'(1)) && (cf_q == sxt_pkg::CH_T || cf_q == sxt_pkg::CH_F);
    fc_tok = (cf_q == sxt_pkg::CH_T) ? sxt_pkg::TK_TRUE : sxt_pkg::TK_FALSE;

    // end of a word
    fw_tok = sxt_pkg::TK_SYMBOL;
    if (mode_q == M_NUMBER && !oth_q && dig_q && dot_q <= 2'd1) begin
      fw_tok = (dot_q == 2'd1) ? sxt_pkg::TK_REAL : sxt_pkg::TK_INT;
    end

    if (mode_q == M_ERR_STRING) begin
      r0 = sxt_pkg::mk_res(sxt_pkg::RK_ERROR, sxt_pkg::TK_EOF, 8'd0, '0,
                           LW'(sline_q), sxt_pkg::ERR_STRING);
      n  = 2'd1;
    end else if (mode_q == M_ERR_CONST) begin
      r0 = sxt_pkg::mk_res(sxt_pkg::RK_ERROR, sxt_pkg::TK_EOF, 8'd0, '0,
                           LW'(line_q), sxt_pkg::ERR_CONST);
      n  = 2'd1;
    end else if (end_of_input_i) begin
      case (mode_q)
        M_STRING, M_ESCAPE: begin
          mode_d = M_ERR_STRING;
          r0 = sxt_pkg::mk_res(sxt_pkg::RK_ERROR, sxt_pkg::TK_EOF, 8'd0, '0,
                               LW'(sline_q), sxt_pkg::ERR_STRING);
          n  = 2'd1;
        end
        M_CONST: begin
          if (fc_ok) begin
            mode_d = M_IDLE;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, fc_tok, 8'd0, NW'(cnt_q),
                                 LW'(line_q), 1'b0);
            r1 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, sxt_pkg::TK_EOF, 8'd0, '0,
                                 LW'(line_q), 1'b0);
            n  = 2'd2;
          end else begin
            mode_d = M_ERR_CONST;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_ERROR, sxt_pkg::TK_EOF, 8'd0, '0,
                                 LW'(line_q), sxt_pkg::ERR_CONST);
            n  = 2'd1;
          end
        end
        M_NUMBER, M_SYMBOL: begin
          mode_d = M_IDLE;
          r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, fw_tok, 8'd0, NW'(cnt_q),
                               LW'(line_q), 1'b0);
          r1 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, sxt_pkg::TK_EOF, 8'd0, '0,
                               LW'(line_q), 1'b0);
          n  = 2'd2;
        end
        default: begin
          mode_d = M_IDLE;
          r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, sxt_pkg::TK_EOF, 8'd0, '0,
                               LW'(line_q), 1'b0);
          n  = 2'd1;
        end
      endcase
    end else begin
      case (mode_q)
        M_COMMENT: begin
          if (c == sxt_pkg::CH_LF) begin
            line_d = line_q + LINE_BITS'(1);
            mode_d = M_IDLE;
          end
        end
        M_STRING: begin
          if (c == sxt_pkg::CH_QUOTE) begin
            mode_d = M_IDLE;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, sxt_pkg::TK_STRING, 8'd0, NW'(cnt_q),
                                 LW'(line_q), 1'b0);
            n  = 2'd1;
          end else if (c == sxt_pkg::CH_BSLASH) begin
            mode_d = M_ESCAPE;
          end else begin
            do_store = 1'b1;
          end
        end
        M_ESCAPE: begin
          if (c == sxt_pkg::CH_N) begin
            c = sxt_pkg::CH_LF;
          end else if (c == sxt_pkg::CH_T) begin
            c = sxt_pkg::CH_TAB;
          end
          do_store = 1'b1;
          mode_d   = M_STRING;
        end
        M_CONST: begin
          if (is_alnum(c) || c == sxt_pkg::CH_UNDER) begin
            do_store = 1'b1;
          end else if (fc_ok) begin
            mode_d  = M_IDLE;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, fc_tok, 8'd0, NW'(cnt_q),
                                 LW'(line_q), 1'b0);
            n  = 2'd1;
            do_idle = 1'b1;
          end else begin
            mode_d = M_ERR_CONST;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_ERROR, sxt_pkg::TK_EOF, 8'd0, '0,
                                 LW'(line_q), sxt_pkg::ERR_CONST);
            n  = 2'd1;
          end
        end
        M_NUMBER, M_SYMBOL: begin
          if (is_space(c) || is_delim(c)) begin
            mode_d  = M_IDLE;
            r0 = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN, fw_tok, 8'd0, NW'(cnt_q),
                                 LW'(line_q), 1'b0);
            n  = 2'd1;
            do_idle = 1'b1;
          end else begin
            do_word = 1'b1;
          end
        end
        default: begin
          mode_d  = M_IDLE;
          do_idle = 1'b1;
        end
      endcase
    end

    // byte seen between tokens
    if (do_idle) begin
      if (is_space(c)) begin
        if (c == sxt_pkg::CH_LF) begin
          line_d = line_d + LINE_BITS'(1);
        end
      end else begin
        case (c)
          sxt_pkg::CH_SEMI: mode_d = M_COMMENT;
          sxt_pkg::CH_OPEN, sxt_pkg::CH_CLOSE: begin
            em = sxt_pkg::mk_res(sxt_pkg::RK_TOKEN,
                                 (c == sxt_pkg::CH_OPEN) ? sxt_pkg::TK_OPEN
                                                         : sxt_pkg::TK_CLOSE,
                                 8'd0, '0, LW'(line_d), 1'b0);
            if (n == 2'd0) begin
              r0 = em;
            end else begin
              r1 = em;
            end
            n = n + 2'd1;
          end
          sxt_pkg::CH_QUOTE: begin
            sline_d = line_d;
            cnt_d   = '0;
            mode_d  = M_STRING;
          end
          sxt_pkg::CH_HASH: begin
            cnt_d  = '0;
            cf_d   = 8'd0;
            mode_d = M_CONST;
          end
          default: begin
            cnt_d   = '0;
            dig_d   = 1'b0;
            oth_d   = 1'b0;
            dot_d   = 2'd0;
            mode_d  = (is_digit(c) || c == sxt_pkg::CH_MINUS) ? M_NUMBER : M_SYMBOL;
            do_word = 1'b1;
          end
        endcase
      end
    end

    // word class flags
    if (do_word) begin
      if (is_digit(c)) begin
        dig_d = 1'b1;
      end else if (c == sxt_pkg::CH_DOT) begin
        if (dot_d < 2'd2) begin
          dot_d = dot_d + 2'd1;
        end
      end else if (is_alnum(c) || c == sxt_pkg::CH_UNDER) begin
        oth_d = 1'b1;
      end
    end

    // text byte, dropped once the length saturates
    if ((do_word || do_store) && cnt_d < MaxT) begin
      if (cnt_d == '0) begin
        cf_d = c;
      end
      cnt_d = cnt_d + TCW'(1);
      em = sxt_pkg::mk_res(sxt_pkg::RK_TEXT, sxt_pkg::TK_EOF, c, '0, LW'(line_d), 1'b0);
      if (n == 2'd0) begin
        r0 = em;
      end else begin
        r1 = em;
      end
      n = n + 2'd1;
    end
  end

  assign push_o        = accept && (n != 2'd0);
  assign entry_o.two   = (n == 2'd2);
  assign entry_o.r0    = r0;
  assign entry_o.r1    = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      cnt_q   <= '0;
      line_q  <= LINE_BITS'(1);
      sline_q <= '0;
      dig_q   <= 1'b0;
      oth_q   <= 1'b0;
      dot_q   <= 2'd0;
      cf_q    <= 8'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      sline_q <= sline_d;
      dig_q   <= dig_d;
      oth_q   <= oth_d;
      dot_q   <= dot_d;
      cf_q    <= cf_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/sxt_queue.sv =====
// short queue of result entries between lexer front and output back end
// depends on sxt_pkg
`default_nettype none
module sxt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sxt_pkg::entry_t  entry_i,
  input  wire logic             pop_i,
  output sxt_pkg::entry_t       head_o,
  output sxt_pkg::q_stat_t      stat_o
);

  localparam int unsigned PW = $clog2(sxt_pkg::Q_DEPTH);
  localparam int unsigned CW = $clog2(sxt_pkg::Q_DEPTH + 1);

  sxt_pkg::entry_t mem_q [sxt_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == CW'(sxt_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(sxt_pkg::Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(sxt_pkg::Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sxt_back.sv =====
// output back end: sends entry results one per cycle unless stalled
// depends on sxt_pkg
`default_nettype none
module sxt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sxt_pkg::entry_t  head_i,
  input  wire sxt_pkg::q_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sxt_pkg::res_t         res_o,
  output logic                  last_o
);

  logic          valid_q;
  logic          sel_q;
  logic          last_q;
  sxt_pkg::res_t res_q;
  logic          load;
  logic          take;
  logic          head_last;

  assign load      = !valid_q || !out_stall_i;
  assign take      = load && !q_stat_i.empty;
  assign head_last = !head_i.two || sel_q;
  assign pop_o     = take && head_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !q_stat_i.empty;
      sel_q   <= take && !head_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= sel_q ? head_i.r1 : head_i.r0;
      last_q <= head_last;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== src/sexpr_tokenizer.sv =====
// s-expression tokenizer top level: lexer front, result queue, output back end
// depends on sxt_pkg, sxt_front, sxt_queue and sxt_back
//
// usage
//   input channel: one request per accepted cycle, a byte (in_byte_i) or an
//   end-of-input mark (end_of_input_i); accepted when in_valid_i is high and
//   in_stall_o is low
//   output channel: one result per accepted cycle (text byte, token or error),
//   accepted when out_valid_o is high and out_stall_i is low; last_result_o
//   marks the final result caused by a request
//   a request gives zero, one or two results
//   path: a result passes through the queue, then the output register
//   throughput: one request per cycle while each gives at most one result and
//   the receiver does not stall; a request with two results holds the output
//   for both, as the single output register drains one queue entry result per cycle
//   the four-entry queue lets the lexer keep taking bytes while the receiver
//   stalls; in_stall_o rises only when the queue is full
//   reset: line count back to one, lexer between tokens, queue and output
//   empty; an error stays until reset and answers every request with itself
`default_nettype none
module sexpr_tokenizer #(
  parameter int unsigned MAX_TEXT  = sxt_pkg::MAX_TEXT_DEF,
  parameter int unsigned LINE_BITS = sxt_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_input_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [3:0]       token_kind_o,
  output logic [7:0]       text_byte_o,
  output logic [10:0]      token_length_o,
  output logic [19:0]      line_number_o,
  output logic             error_code_o,
  output logic             last_result_o
);

  // front to queue
  logic             push;
  sxt_pkg::entry_t  entry;
  // queue to back
  sxt_pkg::entry_t  head;
  sxt_pkg::q_stat_t q_stat;
  logic             pop;
  sxt_pkg::res_t    res;

  // lexer state machine, one request per cycle into the queue while it is not full
  sxt_front #(
    .MAX_TEXT  (MAX_TEXT),
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .entry_o        (entry)
  );

  // decoupling queue, one entry per request that gives results
  sxt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // serialiser and output register
  sxt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_result_o)
  );

  assign result_kind_o  = res.kind;
  assign token_kind_o   = res.tok;
  assign text_byte_o    = res.byte_v;
  assign token_length_o = res.len;
  assign line_number_o  = res.line;
  assign error_code_o   = res.err;

endmodule
`default_nettype wire

// ===== src/sxt_checker.sv =====
// port-level checks for the s-expression tokenizer, bound to the top level
// depends on sxt_pkg and sexpr_tokenizer
`default_nettype none
module sxt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [3:0]  token_kind_o,
  input wire logic [7:0]  text_byte_o,
  input wire logic [10:0] token_length_o,
  input wire logic        error_code_o,
  input wire logic        last_result_o
);

  logic err_seen_q;
  logic out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_acc && result_kind_o == sxt_pkg::RK_ERROR) begin
      err_seen_q <= 1'b1;
    end
  end

  // a stalled result stays offered
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // once an error has gone out, nothing but errors follows
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q |-> result_kind_o == sxt_pkg::RK_ERROR)
    else $error("non-error result after an error");

  // end of file token closes its request
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sxt_pkg::RK_TOKEN && token_kind_o == sxt_pkg::TK_EOF
    |-> last_result_o)
    else $error("eof token not last");

  // text results carry the byte but no token kind, length or error code
  a_text_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sxt_pkg::RK_TEXT
    |-> token_kind_o == sxt_pkg::TK_EOF && token_length_o == 11'd0 && error_code_o == 1'b0)
    else $error("text result with token fields set");

  // tokens carry no text byte and no error code
  a_token_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == sxt_pkg::RK_TOKEN
    |-> text_byte_o == 8'd0 && error_code_o == 1'b0)
    else $error("token result with text or error fields set");

endmodule

bind sexpr_tokenizer sxt_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_kind_o  (result_kind_o),
  .token_kind_o   (token_kind_o),
  .text_byte_o    (text_byte_o),
  .token_length_o (token_length_o),
  .error_code_o   (error_code_o),
  .last_result_o  (last_result_o)
);
`default_nettype wire

// ===== bench/tb_sexpr_tokenizer.sv =====
// self-checking bench for the s-expression tokenizer: scoreboard class, drivers, run control
// depends on sxt_pkg and sexpr_tokenizer
`timescale 1ns / 100ps
module tb_sexpr_tokenizer;
  import sxt_pkg::*;

  // run shape
  localparam int unsigned ITEM_TARGET  = 1750;    // requests over the whole run
  localparam int unsigned MAX_TEXT     = MAX_TEXT_DEF;
  localparam int unsigned SAT_REQS     = MAX_TEXT + 9;  // long number and its ending space
  localparam int unsigned TAIL_REQS    = 16;
  localparam int unsigned RAND_REQS    = ITEM_TARGET - SAT_REQS - TAIL_REQS;
  localparam int unsigned IDLE_PCT     = 32;
  localparam int unsigned HOLD_AFTER   = 200;     // requests before the long result hold-off
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned CALM_FROM    = 400;
  localparam int unsigned CALM_TO      = 650;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // zero fields of results that carry no token or error
  localparam logic [3:0] TK_NONE  = 4'd0;
  localparam logic       ERR_NONE = 1'b0;

  // character classes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;

  // one expected result and the last-result flag that goes with it
  typedef struct packed {
    res_t r;
    logic last;
  } lex_res_t;

  // one request as offered to the block
  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
  } lex_req_t;

  // lexer model plus the store of results it predicts
  class lex_scoreboard;
    typedef enum logic [3:0] {
      LX_IDLE, LX_COMMENT, LX_STRING, LX_ESCAPE, LX_CONST,
      LX_NUMBER, LX_SYMBOL, LX_ERR_STR, LX_ERR_CONST
    } lex_mode_e;

    lex_mode_e         mode;
    int unsigned       text_cnt;
    logic [LINE_W-1:0] line_cnt;
    logic [LINE_W-1:0] str_line;
    bit                seen_dig;
    bit                seen_alnum;
    int unsigned       dots;
    logic [7:0]        first_ch;

    res_t     step_res[$];
    lex_res_t awaited[$];

    int unsigned requests    = 0;
    int unsigned productive  = 0;
    int unsigned checked     = 0;
    int unsigned text_seen   = 0;
    int unsigned tokens_seen = 0;
    int unsigned errors_seen = 0;
    int unsigned mismatches  = 0;

    function new();
      restart();
    endfunction

    function void restart();
      mode       = LX_IDLE;
      text_cnt   = 0;
      line_cnt   = 1;
      str_line   = '0;
      seen_dig   = 1'b0;
      seen_alnum = 1'b0;
      dots       = 0;
      first_ch   = 8'h00;
    endfunction

    static function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    static function bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    static function bit is_alnum(logic [7:0] c);
      return is_digit(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    static function bit is_delim(logic [7:0] c);
      return c == CH_QUOTE || c == CH_OPEN || c == CH_CLOSE || c == CH_SEMI;
    endfunction

    function void push_res(logic [1:0] kind, logic [3:0] tok, logic [7:0] b,
                           int unsigned len, logic [LINE_W-1:0] line, logic err);
      res_t r;
      r.kind   = kind;
      r.tok    = tok;
      r.byte_v = b;
      r.len    = LEN_W'(len);
      r.line   = line;
      r.err    = err;
      step_res.push_back(r);
    endfunction

    function void push_token(logic [3:0] tok, int unsigned len);
      push_res(RK_TOKEN, tok, 8'h00, len, line_cnt, ERR_NONE);
    endfunction

    function void push_error();
      if (mode == LX_ERR_STR) begin
        push_res(RK_ERROR, TK_NONE, 8'h00, 0, str_line, ERR_STRING);
      end else begin
        push_res(RK_ERROR, TK_NONE, 8'h00, 0, line_cnt, ERR_CONST);
      end
    endfunction

    // bytes past the text limit are dropped without a result
    function void store_text(logic [7:0] c);
      if (text_cnt < MAX_TEXT) begin
        if (text_cnt == 0) first_ch = c;
        text_cnt++;
        push_res(RK_TEXT, TK_NONE, c, 0, line_cnt, ERR_NONE);
      end
    endfunction

    function void word_byte(logic [7:0] c);
      if (is_digit(c)) begin
        seen_dig = 1'b1;
      end else if (c == CH_DOT) begin
        if (dots < 2) dots++;
      end else if (is_alnum(c) || c == CH_UNDER) begin
        seen_alnum = 1'b1;
      end
      store_text(c);
    endfunction

    function void idle_byte(logic [7:0] c);
      if (is_space(c)) begin
        if (c == CH_LF) line_cnt++;
        return;
      end
      case (c)
        CH_SEMI: begin
          mode = LX_COMMENT;
          return;
        end
        CH_OPEN: begin
          push_token(TK_OPEN, 0);
          return;
        end
        CH_CLOSE: begin
          push_token(TK_CLOSE, 0);
          return;
        end
        CH_QUOTE: begin
          str_line = line_cnt;
          text_cnt = 0;
          mode     = LX_STRING;
          return;
        end
        CH_HASH: begin
          text_cnt = 0;
          first_ch = 8'h00;
          mode     = LX_CONST;
          return;
        end
        default: ;
      endcase
      text_cnt   = 0;
      seen_dig   = 1'b0;
      seen_alnum = 1'b0;
      dots       = 0;
      mode       = (is_digit(c) || c == CH_MINUS) ? LX_NUMBER : LX_SYMBOL;
      word_byte(c);
    endfunction

    function void finish_word();
      logic [3:0] tok;
      tok = TK_SYMBOL;
      if (mode == LX_NUMBER && !seen_alnum && seen_dig && dots <= 1)
        tok = (dots == 1) ? TK_REAL : TK_INT;
      push_token(tok, text_cnt);
      mode = LX_IDLE;
    endfunction

    // only a single stored t or f is a known constant
    function bit finish_const();
      if (text_cnt == 1 && first_ch == CH_T) begin
        push_token(TK_TRUE, text_cnt);
      end else if (text_cnt == 1 && first_ch == CH_F) begin
        push_token(TK_FALSE, text_cnt);
      end else begin
        mode = LX_ERR_CONST;
        push_error();
        return 1'b0;
      end
      mode = LX_IDLE;
      return 1'b1;
    endfunction

    // steps the model on an accepted request and queues what it gives
    function int note_request(logic [7:0] b, logic eoi);
      logic [7:0] c;
      lex_res_t   e;
      c = b;
      step_res.delete();
      if (mode == LX_ERR_STR || mode == LX_ERR_CONST) begin
        push_error();
      end else if (eoi) begin
        case (mode)
          LX_STRING, LX_ESCAPE: begin
            mode = LX_ERR_STR;
            push_error();
          end
          LX_CONST: begin
            if (finish_const()) push_token(TK_EOF, 0);
          end
          LX_NUMBER, LX_SYMBOL: begin
            finish_word();
            push_token(TK_EOF, 0);
          end
          default: begin
            mode = LX_IDLE;
            push_token(TK_EOF, 0);
          end
        endcase
      end else begin
        case (mode)
          LX_COMMENT: begin
            if (c == CH_LF) begin
              line_cnt++;
              mode = LX_IDLE;
            end
          end
          LX_STRING: begin
            if (c == CH_QUOTE) begin
              push_token(TK_STRING, text_cnt);
              mode = LX_IDLE;
            end else if (c == CH_BSLASH) begin
              mode = LX_ESCAPE;
            end else begin
              store_text(c);
            end
          end
          LX_ESCAPE: begin
            if (c == CH_N) c = CH_LF;
            else if (c == CH_T) c = CH_TAB;
            store_text(c);
            mode = LX_STRING;
          end
          LX_CONST: begin
            if (is_alnum(c) || c == CH_UNDER) store_text(c);
            else if (finish_const()) idle_byte(c);
          end
          LX_NUMBER, LX_SYMBOL: begin
            if (is_space(c) || is_delim(c)) begin
              finish_word();
              idle_byte(c);
            end else begin
              word_byte(c);
            end
          end
          default: begin
            mode = LX_IDLE;
            idle_byte(c);
          end
        endcase
      end
      foreach (step_res[i]) begin
        e.r    = step_res[i];
        e.last = (i == step_res.size() - 1);
        awaited.push_back(e);
      end
      requests++;
      if (step_res.size() != 0) productive++;
      return step_res.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task check_result(res_t got, logic got_last);
      lex_res_t want;
      checked++;
      case (got.kind)
        RK_TEXT:  text_seen++;
        RK_TOKEN: tokens_seen++;
        default:  errors_seen++;
      endcase
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %0d with none expected: kind %0d tok %0d byte %02h",
                                  checked, got.kind, got.tok, got.byte_v));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.r.kind || got.tok !== want.r.tok ||
          got.byte_v !== want.r.byte_v || got.len !== want.r.len ||
          got.line !== want.r.line || got.err !== want.r.err || got_last !== want.last) begin
        report_mismatch($sformatf(
          "result %0d: got k%0d t%0d b%02h n%0d l%0d e%0d z%0d want k%0d t%0d b%02h n%0d l%0d e%0d z%0d",
          checked, got.kind, got.tok, got.byte_v, got.len, got.line, got.err, got_last,
          want.r.kind, want.r.tok, want.r.byte_v, want.r.len, want.r.line, want.r.err,
          want.last));
      end
    endtask
  endclass

  // block ports
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [3:0]  token_kind_o;
  logic [7:0]  text_byte_o;
  logic [10:0] token_length_o;
  logic [19:0] line_number_o;
  logic        error_code_o;
  logic        last_result_o;

  sexpr_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .token_kind_o   (token_kind_o),
    .text_byte_o    (text_byte_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .error_code_o   (error_code_o),
    .last_result_o  (last_result_o)
  );

  lex_scoreboard sb = new();
  lex_req_t      req_q[$];       // requests built but not yet offered
  bit            calm = 1'b0;    // both sides run without idling while set
  int unsigned   stall_seen = 0; // edges at which a request was held back
  int unsigned   cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // request building: pieces are queued here and offered by send_queued
  // ---------------------------------------------------------------------

  function automatic void put_char(logic [7:0] c);
    lex_req_t q;
    q.eoi = 1'b0;
    q.b   = c;
    req_q.push_back(q);
  endfunction

  // the byte that rides with an end-of-input mark is random, it must be ignored
  function automatic void put_eoi();
    lex_req_t q;
    q.eoi = 1'b1;
    q.b   = 8'($urandom_range(0, 255));
    req_q.push_back(q);
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] r;
    r = 8'($urandom_range(CH_TAB, CH_CR + 1));
    if (r > CH_CR) r = CH_SPACE;
    return r;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(CH_0, CH_9));
  endfunction

  // anything that keeps a word going, non-ascii and control bytes included
  function automatic logic [7:0] rand_word_char();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255));
    while (lex_scoreboard::is_space(r) || lex_scoreboard::is_delim(r));
    return r;
  endfunction

  // one stored string character: plain byte or an escape of any byte
  function automatic void add_string_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      put_char(CH_BSLASH);
      case ($urandom_range(0, 2))
        0:       put_char(CH_N);
        1:       put_char(CH_T);
        default: put_char(8'($urandom_range(0, 255)));
      endcase
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_QUOTE || c == CH_BSLASH);
      put_char(c);
    end
  endfunction

  function automatic void add_string(int unsigned n);
    put_char(CH_QUOTE);
    repeat (n) add_string_char();
    put_char(CH_QUOTE);
  endfunction

  // ends a word or constant; end of input here gives two results from one request
  function automatic void add_word_end();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: put_char(rand_space());
      5:             put_char(CH_OPEN);
      6:             put_char(CH_CLOSE);
      7: begin
        put_char(CH_SEMI);
        put_char(CH_LF);
      end
      default:       put_eoi();
    endcase
  endfunction

  // mostly well-formed tokens; noise never opens a string, comment or constant,
  // so no error can arise before the tail of the run
  function automatic void add_random_piece();
    logic [7:0] c;
    int unsigned n;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        n = $urandom_range(1, 3);
        repeat (n) put_char(rand_space());
      end
      3, 4: put_char(CH_OPEN);
      5, 6: put_char(CH_CLOSE);
      7: begin
        put_char(CH_SEMI);
        n = $urandom_range(0, 8);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_LF);
          put_char(c);
        end
        put_char(CH_LF);
      end
      8, 9, 10: add_string($urandom_range(0, 10));
      11: begin
        put_char(CH_HASH);
        put_char($urandom_range(0, 1) ? CH_T : CH_F);
        add_word_end();
      end
      12, 13, 14: begin
        // integers, reals and the malformed numbers that fall back to symbols
        put_char($urandom_range(0, 2) == 0 ? CH_MINUS : rand_digit());
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 19))
            14, 15, 16: put_char(CH_DOT);
            17, 18, 19: put_char(rand_word_char());
            default:    put_char(rand_digit());
          endcase
        end
        add_word_end();
      end
      15, 16, 17: begin
        do c = rand_word_char();
        while (c == CH_HASH || c == CH_MINUS || lex_scoreboard::is_digit(c));
        put_char(c);
        n = $urandom_range(0, 6);
        repeat (n) put_char(rand_word_char());
        add_word_end();
      end
      18: put_eoi();
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_HASH || c == CH_QUOTE || c == CH_SEMI);
          put_char(c);
        end
      end
    endcase
  endfunction

  // a number longer than the text limit with at most one dot, which may land past the
  // point where bytes stop being stored
  function automatic void add_saturating_tokens();
    int unsigned dot_at;
    put_char(CH_SPACE);
    dot_at = $urandom_range(1, 2 * MAX_TEXT);
    put_char(rand_digit());
    for (int unsigned i = 1; i < MAX_TEXT + 8; i++)
      put_char(i == dot_at ? CH_DOT : rand_digit());
    put_char(CH_SPACE);
  endfunction

  // the error is sticky until reset, so one kind of error closes the run,
  // followed by a few requests that must all repeat it
  function automatic void add_error_tail();
    logic [7:0] c;
    int unsigned n;
    if ($urandom_range(0, 1)) begin
      // unterminated string, possibly inside an escape
      put_char(CH_QUOTE);
      n = $urandom_range(0, 4);
      repeat (n) add_string_char();
      if ($urandom_range(0, 1)) put_char(CH_BSLASH);
      put_eoi();
    end else begin
      // unknown constant: empty, too long, or a single character other than t or f
      put_char(CH_HASH);
      n = $urandom_range(0, 3);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255));
        while (!(lex_scoreboard::is_alnum(c) || c == CH_UNDER) ||
               (n == 1 && (c == CH_T || c == CH_F)));
        put_char(c);
      end
      if ($urandom_range(0, 1)) begin
        put_eoi();
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (lex_scoreboard::is_alnum(c) || c == CH_UNDER);
        put_char(c);
      end
    end
    n = $urandom_range(4, 8);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) put_eoi();
      else put_char(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // valid is only lowered when the sender chooses to idle, never because of stall
  task automatic send_request(input logic [7:0] b, input logic eoi);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) begin
      stall_seen++;
      @(posedge clk_i);
    end
    void'(sb.note_request(b, eoi));
  endtask

  task automatic send_queued();
    lex_req_t q;
    while (req_q.size() != 0) begin
      q = req_q.pop_front();
      send_request(q.b, q.eoi);
    end
  endtask

  // ---------------------------------------------------------------------
  // result side: random stalls, one long hold-off to fill the queue
  // ---------------------------------------------------------------------
  initial begin
    res_t        got;
    logic        stall_now;
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_left != 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else if (!hold_done && sb.requests >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall_now = 1'b1;
      end else begin
        stall_now = !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
      out_stall_i <= stall_now;
      @(posedge clk_i);
      if (out_valid_o && !stall_now) begin
        got.kind   = result_kind_o;
        got.tok    = token_kind_o;
        got.byte_v = text_byte_o;
        got.len    = token_length_o;
        got.line   = line_number_o;
        got.err    = error_code_o;
        sb.check_result(got, last_result_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    in_byte_i      <= 8'h00;
    end_of_input_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening: every token kind, a constant ended by a delimiter (two
    // results), a word ended by a delimiter, escapes including a literal one,
    // newlines in and out of strings, a quote inside a comment, a non-ascii
    // symbol and the byte extremes, closed by end of input after a pending word
    put_char(CH_OPEN);
    put_char(CH_HASH);
    put_char(CH_T);
    put_char(CH_CLOSE);
    put_char(CH_HASH);
    put_char(CH_F);
    put_char(CH_SPACE);
    put_char(CH_MINUS);
    put_char("7");
    put_char(CH_LF);
    put_char("1");
    put_char(CH_DOT);
    put_char("5");
    put_char(CH_QUOTE);
    put_char(CH_BSLASH);
    put_char(CH_N);
    put_char(CH_BSLASH);
    put_char("q");
    put_char(8'h00);
    put_char(CH_LF);
    put_char(CH_QUOTE);
    put_char(CH_SEMI);
    put_char(CH_QUOTE);
    put_char(CH_LF);
    put_char(8'hFF);
    put_eoi();
    send_queued();

    // random token stream, with a window where neither side idles
    while (sb.requests < RAND_REQS) begin
      calm = (sb.requests >= CALM_FROM && sb.requests < CALM_TO);
      add_random_piece();
      send_queued();
    end
    calm = 1'b0;

    add_saturating_tokens();
    send_queued();
    add_error_tail();
    send_queued();
    in_valid_i <= 1'b0;

    // let every expected result arrive, then watch for strays
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.awaited.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));

    $display("run: %0d requests (%0d with results), %0d results (%0d text, %0d tokens, %0d errors)",
             sb.requests, sb.productive, sb.checked, sb.text_seen, sb.tokens_seen,
             sb.errors_seen);
    $display("run: requests held back on %0d edges, %0d result mismatches",
             stall_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
